FILE: rtl/sfoc_pkg.sv
// ----------------------------------------------------------------------------
// sfoc_pkg
// Shared types and codes for the stage force output controller: command
// codes, layout codes, register indexes and the word formats of both channels.
// ----------------------------------------------------------------------------
package sfoc_pkg;

    // relay outputs on the card
    localparam int NUM_OUTPUTS = 16;

    // command codes
    typedef enum logic [2:0] {
        CMD_SYNC_ON   = 3'd0,
        CMD_SYNC_OFF  = 3'd1,
        CMD_CHANGE    = 3'd2,
        CMD_JUST_ON   = 3'd3,
        CMD_OFF       = 3'd4,
        CMD_FAULT_ON  = 3'd5,
        CMD_FAULT_OFF = 3'd6,
        CMD_NONE      = 3'd7
    } t_cmd;

    // layout codes, the unused fourth code behaves as the sixteen-output card
    localparam logic [1:0] LAYOUT_SIXTEEN = 2'd0;
    localparam logic [1:0] LAYOUT_LEGACY  = 2'd1;
    localparam logic [1:0] LAYOUT_TEST    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_LAYOUT_MODE = 2'd0;
    localparam logic [1:0] REG_SYNC_ENABLE = 2'd1;
    localparam logic [1:0] REG_ACTIVE_HIGH = 2'd2;
    localparam logic [1:0] REG_STAGE_COUNT = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // configuration register file contents
    typedef struct packed {
        logic [1:0] layout_mode;
        logic       sync_enable;
        logic       active_high;
        logic [4:0] stage_count;
    } t_cfg;

    // input word
    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] stage_demand;
    } t_in;

    // result word, also the block state
    typedef struct packed {
        logic [15:0] output_word;
        logic [4:0]  active_stage;
        logic        fault_lamp;
    } t_out;

endpackage

FILE: rtl/stage_force_output_controller_top.sv
// One command word is accepted every clock cycle while o_stall is low. The
// command passes through an input register and then a result register, which
// offers its result word. Each result shows the relay word, forced stage and
// lamp after that command. While a result word is held, one more command can
// still enter the input register. After that the input stalls until the held
// result is taken. Configuration writes are taken at any cycle but belong only
// to times when no word is in flight.
// ----------------------------------------------------------------------------
// stage_force_output_controller_top
// Stage force output controller: priority-encodes the stage demand and
// updates the 16-bit relay output word for each command.
// ----------------------------------------------------------------------------
module stage_force_output_controller_top #(
    parameter int MAX_STAGES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  sfoc_pkg::t_in                    i_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output sfoc_pkg::t_out                   o_out,
    input  logic                             i_cfg_we,
    input  logic [sfoc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfoc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    sfoc_pkg::t_cfg cfg;
    sfoc_pkg::t_in  r_in;
    logic           r_in_valid;
    sfoc_pkg::t_out r_state;
    sfoc_pkg::t_out n_state;
    sfoc_pkg::t_out r_out;
    logic           r_out_valid;
    logic [4:0]     new_stage;
    logic           advance;
    logic           take_in;

    sfoc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // handshake: the held word moves on when the result register is free or its word is taken
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign take_in = !r_in_valid || advance;
    assign o_stall = !take_in;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in && i_valid) begin
            r_in <= i_in;
        end
    end

    sfoc_prienc #(
        .MAX_STAGES (MAX_STAGES)
    ) u_prienc (
        .i_demand      (r_in.stage_demand),
        .i_stage_count (cfg.stage_count),
        .o_stage       (new_stage)
    );

    sfoc_update u_update (
        .i_cfg       (cfg),
        .i_cmd       (r_in.cmd),
        .i_new_stage (new_stage),
        .i_state     (r_state),
        .o_state     (n_state)
    );

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_state;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

FILE: rtl/sfoc_cfg.sv
// ----------------------------------------------------------------------------
// sfoc_cfg
// Configuration register file: layout, sync enable, polarity and stage count.
// ----------------------------------------------------------------------------
module sfoc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sfoc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfoc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sfoc_pkg::t_cfg                   o_cfg
);

    sfoc_pkg::t_cfg r_cfg;

    // register writes, one index per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layout_mode <= sfoc_pkg::LAYOUT_SIXTEEN;
            r_cfg.sync_enable <= 1'b0;
            r_cfg.active_high <= 1'b1;
            r_cfg.stage_count <= 5'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfoc_pkg::REG_LAYOUT_MODE: r_cfg.layout_mode <= i_cfg_data[1:0];
                sfoc_pkg::REG_SYNC_ENABLE: r_cfg.sync_enable <= i_cfg_data[0];
                sfoc_pkg::REG_ACTIVE_HIGH: r_cfg.active_high <= i_cfg_data[0];
                sfoc_pkg::REG_STAGE_COUNT: r_cfg.stage_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/sfoc_prienc.sv
// ----------------------------------------------------------------------------
// sfoc_prienc
// Priority encoder: highest demanded stage within the configured stage count.
// ----------------------------------------------------------------------------
module sfoc_prienc #(
    parameter int MAX_STAGES = 16
) (
    input  logic [15:0] i_demand,
    input  logic [4:0]  i_stage_count,
    output logic [4:0]  o_stage
);

    localparam logic [4:0] LP_MAX = 5'(MAX_STAGES);

    logic [4:0] count;

    // clamp the stage count to the supported maximum
    assign count = (i_stage_count > LP_MAX) ? LP_MAX : i_stage_count;

    // later bits win
    always_comb begin
        o_stage = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (i_demand[i] && (5'(i) < count)) begin
                o_stage = 5'(i + 1);
            end
        end
    end

endmodule

FILE: rtl/sfoc_update.sv
// ----------------------------------------------------------------------------
// sfoc_update
// Applies one command to the output state: layout lookup, change-stage
// promotion and polarity-aware set and clear of the relay bits.
// ----------------------------------------------------------------------------
module sfoc_update (
    input  sfoc_pkg::t_cfg  i_cfg,
    input  logic [2:0]      i_cmd,
    input  logic [4:0]      i_new_stage,
    input  sfoc_pkg::t_out  i_state,
    output sfoc_pkg::t_out  o_state
);

    // bit of the force output for a stage, none for stage zero or off the card
    function automatic logic [15:0] force_mask(input logic first, input logic [4:0] stage);
        logic [5:0] idx;
        idx = 6'(first) + 6'(stage) - 6'd1;
        if (stage == 5'd0) begin
            return 16'h0000;
        end
        if (idx >= 6'(sfoc_pkg::NUM_OUTPUTS)) begin
            return 16'h0000;
        end
        return 16'h0001 << idx[3:0];
    endfunction

    logic        first;
    logic [15:0] range_mask;
    logic [15:0] hi_mask;
    logic [15:0] to_mask;
    logic [15:0] sp_mask;
    logic [15:0] mf_mask;
    logic [15:0] sync_mask;
    logic [15:0] old_force;
    logic [15:0] new_force;
    logic [15:0] on_bits;
    logic [15:0] off_bits;
    logic [15:0] bits;
    logic [2:0]  cmd;

    // layout table
    always_comb begin
        case (i_cfg.layout_mode)
            sfoc_pkg::LAYOUT_LEGACY: begin
                first      = 1'b1;
                range_mask = 16'h01FE;
                hi_mask    = 16'h0000;
                to_mask    = 16'h0001;
                sp_mask    = 16'h0400;
                mf_mask    = 16'h0200;
            end
            sfoc_pkg::LAYOUT_TEST: begin
                first      = 1'b0;
                range_mask = 16'h00FF;
                hi_mask    = 16'h0100;
                to_mask    = 16'h0200;
                sp_mask    = 16'h0400;
                mf_mask    = 16'h0000;
            end
            default: begin
                first      = 1'b0;
                range_mask = 16'h1FFF;
                hi_mask    = 16'h0000;
                to_mask    = 16'h8000;
                sp_mask    = 16'h4000;
                mf_mask    = 16'h2000;
            end
        endcase
    end

    assign sync_mask = i_cfg.sync_enable ? sp_mask : 16'h0000;
    assign old_force = force_mask(first, i_state.active_stage);
    assign new_force = force_mask(first, i_new_stage);

    // change stage becomes just-on when idle and none when unchanged
    always_comb begin
        cmd = i_cmd;
        if (i_cmd == sfoc_pkg::CMD_CHANGE) begin
            if ((i_state.active_stage == 5'd0) && (i_new_stage != 5'd0)) begin
                cmd = sfoc_pkg::CMD_JUST_ON;
            end else if (i_state.active_stage == i_new_stage) begin
                cmd = sfoc_pkg::CMD_NONE;
            end
        end
    end

    // bits to drive inactive and active, in that order of application
    always_comb begin
        on_bits    = 16'h0000;
        off_bits   = 16'h0000;
        o_state    = i_state;
        unique case (cmd)
            sfoc_pkg::CMD_SYNC_ON:   on_bits  = sync_mask;
            sfoc_pkg::CMD_SYNC_OFF:  off_bits = sync_mask;
            sfoc_pkg::CMD_CHANGE: begin
                off_bits = old_force;
                on_bits  = new_force;
                o_state.active_stage = i_new_stage;
            end
            sfoc_pkg::CMD_JUST_ON: begin
                on_bits = new_force | hi_mask | to_mask;
                o_state.active_stage = i_new_stage;
                o_state.fault_lamp   = 1'b1;
            end
            sfoc_pkg::CMD_OFF: begin
                off_bits = range_mask | hi_mask | to_mask;
                o_state.active_stage = 5'd0;
                o_state.fault_lamp   = 1'b0;
            end
            sfoc_pkg::CMD_FAULT_ON:  on_bits  = mf_mask;
            sfoc_pkg::CMD_FAULT_OFF: off_bits = mf_mask;
            default: ;
        endcase
        // inactive drive first, then active, each with the set polarity
        bits = i_state.output_word;
        if (i_cfg.active_high) begin
            bits = bits & ~off_bits;
            bits = bits | on_bits;
        end else begin
            bits = bits | off_bits;
            bits = bits & ~on_bits;
        end
        o_state.output_word = bits;
    end

endmodule

FILE: rtl/sfoc_checker.sv
// ----------------------------------------------------------------------------
// sfoc_checker
// Port-level checks on the stage force output controller.
// ----------------------------------------------------------------------------
module sfoc_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           o_stall,
    input  logic           o_valid,
    input  logic           i_stall,
    input  sfoc_pkg::t_out o_out
);

    // no result word right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("stalled result word changed");

    // with the result side empty the input side is never stalled
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while result register empty");

    // a forced stage only exists after just-on, which lights the lamp
    a_stage_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.active_stage != 5'd0) |-> o_out.fault_lamp)
        else $error("stage forced with lamp off");

    // stage never exceeds sixteen
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.active_stage <= 5'd16))
        else $error("active stage out of range");

endmodule

bind stage_force_output_controller_top sfoc_checker u_sfoc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
